/* sv/pas_pkg.sv */
package pas_pkg;

  // coordinate width and arctangent iteration count
  localparam int COORD_BITS   = 24;
  localparam int CORDIC_STEPS = 20;

  // arctangent table depth and the iterations actually run
  localparam int ATAN_LEN   = 24;
  localparam int NSTEPS     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int ITER_W     = $clog2(NSTEPS);
  localparam int ATAN_IDX_W = $clog2(ATAN_LEN);

  // datapath widths
  localparam int DELTA_W = COORD_BITS + 1;
  localparam int FRAC_W  = 16;
  localparam int CW      = DELTA_W + FRAC_W + 3;
  localparam int ZW      = 26;
  localparam int DIR_W   = 17;
  localparam int ANG_W   = 17;

  // angle constants, coarse in 1/256 degree, fine in 1/65536 degree
  localparam logic [DIR_W-1:0] DIR_EAST  = DIR_W'(0);
  localparam logic [DIR_W-1:0] DIR_NORTH = DIR_W'(23040);
  localparam logic [DIR_W-1:0] DIR_WEST  = DIR_W'(46080);
  localparam logic [DIR_W-1:0] DIR_SOUTH = DIR_W'(69120);
  localparam logic [DIR_W-1:0] FULL_TURN = DIR_W'(92160);
  localparam logic [ANG_W-1:0] HALF_DEGREE = ANG_W'(128);
  localparam logic signed [ZW-1:0] FULL_TURN_FINE = ZW'(23592960);
  localparam logic signed [ZW-1:0] HALF_TURN_FINE = ZW'(11796480);
  localparam logic signed [ZW-1:0] ROUND_HALF     = ZW'(128);

  // draw modes
  localparam logic [1:0] MODE_RAW      = 2'd0;
  localparam logic [1:0] MODE_CURVE    = 2'd1;
  localparam logic [1:0] MODE_STRAIGHT = 2'd2;

  // accepted point count in a stroke
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  // register map
  localparam int REG_ADDR_W = 4;
  localparam logic [1:0] REG_DRAW_MODE = 2'd0;
  localparam logic [1:0] REG_OPTIMIZE  = 2'd1;
  localparam logic [1:0] REG_COMBINE   = 2'd2;

  // microcode step address
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // datapath operation of one microcode step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_CHECK,
    OP_SETUP,
    OP_ITER,
    OP_NORM,
    OP_EMIT_MID,
    OP_UPDATE,
    OP_EMIT_LAST,
    OP_CLEAR
  } op_t;

  // jump condition of one microcode step
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_FIRST_OR_DUP,
    COND_AXIS,
    COND_LOOP,
    COND_DROP,
    COND_OUT_BUSY,
    COND_NOT_END,
    COND_SHORT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctl_word_t;

  // status from the datapath that the sequencer branches on
  typedef struct packed {
    logic no_req;
    logic first_or_dup;
    logic axis;
    logic loop;
    logic drop;
    logic out_busy;
    logic not_end;
    logic short_stroke;
  } flags_t;

  typedef struct packed {
    logic [1:0]       draw_mode;
    logic             optimize_enable;
    logic [ANG_W-1:0] combine_angle;
  } cfg_t;

endpackage

/* sv/pas_regs.sv */
module pas_regs
  import pas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.draw_mode       <= MODE_RAW;
      cfg_r.optimize_enable <= 1'b0;
      cfg_r.combine_angle   <= ANG_W'(3840);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DRAW_MODE: cfg_r.draw_mode       <= pwdata[1:0];
        REG_OPTIMIZE:  cfg_r.optimize_enable <= pwdata[0];
        REG_COMBINE:   cfg_r.combine_angle   <= pwdata[ANG_W-1:0];
        default:       ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_DRAW_MODE: prdata = {30'd0, cfg_r.draw_mode};
      REG_OPTIMIZE:  prdata = {31'd0, cfg_r.optimize_enable};
      REG_COMBINE:   prdata = {{(32-ANG_W){1'b0}}, cfg_r.combine_angle};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

/* sv/pas_cordic.sv */
module pas_cordic
  import pas_pkg::*;
(
  input  logic signed [CW-1:0] x,
  input  logic signed [CW-1:0] y,
  input  logic signed [ZW-1:0] z,
  input  logic [ITER_W-1:0]    iter,
  output logic signed [CW-1:0] x_step,
  output logic signed [CW-1:0] y_step,
  output logic signed [ZW-1:0] z_step
);

  // arctangent of 2^-i in 1/65536 degree
  function automatic logic signed [ZW-1:0] atan_fine(input logic [ATAN_IDX_W-1:0] i);
    unique case (i)
      5'd0:    atan_fine = ZW'(2949120);
      5'd1:    atan_fine = ZW'(1740967);
      5'd2:    atan_fine = ZW'(919879);
      5'd3:    atan_fine = ZW'(466945);
      5'd4:    atan_fine = ZW'(234379);
      5'd5:    atan_fine = ZW'(117304);
      5'd6:    atan_fine = ZW'(58666);
      5'd7:    atan_fine = ZW'(29335);
      5'd8:    atan_fine = ZW'(14668);
      5'd9:    atan_fine = ZW'(7334);
      5'd10:   atan_fine = ZW'(3667);
      5'd11:   atan_fine = ZW'(1833);
      5'd12:   atan_fine = ZW'(917);
      5'd13:   atan_fine = ZW'(458);
      5'd14:   atan_fine = ZW'(229);
      5'd15:   atan_fine = ZW'(115);
      5'd16:   atan_fine = ZW'(57);
      5'd17:   atan_fine = ZW'(29);
      5'd18:   atan_fine = ZW'(14);
      5'd19:   atan_fine = ZW'(7);
      5'd20:   atan_fine = ZW'(4);
      5'd21:   atan_fine = ZW'(2);
      5'd22:   atan_fine = ZW'(1);
      default: atan_fine = ZW'(0);
    endcase
  endfunction

  logic signed [CW-1:0] x_sh;
  logic signed [CW-1:0] y_sh;
  logic signed [ZW-1:0] atan_val;
  logic                 y_pos;

  assign x_sh     = x >>> iter;
  assign y_sh     = y >>> iter;
  assign atan_val = atan_fine(ATAN_IDX_W'(iter));
  assign y_pos    = !y[CW-1] && (y != '0);

  // one vectoring rotation toward the x axis
  always_comb begin
    if (y_pos) begin
      x_step = x + y_sh;
      y_step = y - x_sh;
      z_step = z + atan_val;
    end else begin
      x_step = x - y_sh;
      y_step = y + x_sh;
      z_step = z - atan_val;
    end
  end

endmodule

/* sv/pas_seq.sv */
module pas_seq
  import pas_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output op_t    op
);

  // step addresses of the program
  localparam step_t ST_WAIT      = STEP_W'(0);
  localparam step_t ST_CHECK     = STEP_W'(1);
  localparam step_t ST_SETUP     = STEP_W'(2);
  localparam step_t ST_ITER      = STEP_W'(3);
  localparam step_t ST_NORM      = STEP_W'(4);
  localparam step_t ST_DECIDE    = STEP_W'(5);
  localparam step_t ST_EMIT_MID  = STEP_W'(6);
  localparam step_t ST_UPDATE    = STEP_W'(7);
  localparam step_t ST_END_CHK   = STEP_W'(8);
  localparam step_t ST_LAST_CHK  = STEP_W'(9);
  localparam step_t ST_EMIT_LAST = STEP_W'(10);
  localparam step_t ST_CLEAR     = STEP_W'(11);

  // control store
  function automatic ctl_word_t rom(input step_t s);
    unique case (s)
      ST_WAIT:      rom = '{OP_ACCEPT,    COND_NO_REQ,       ST_WAIT};
      ST_CHECK:     rom = '{OP_CHECK,     COND_FIRST_OR_DUP, ST_END_CHK};
      ST_SETUP:     rom = '{OP_SETUP,     COND_AXIS,         ST_DECIDE};
      ST_ITER:      rom = '{OP_ITER,      COND_LOOP,         ST_ITER};
      ST_NORM:      rom = '{OP_NORM,      COND_NEVER,        ST_WAIT};
      ST_DECIDE:    rom = '{OP_NOP,       COND_DROP,         ST_UPDATE};
      ST_EMIT_MID:  rom = '{OP_EMIT_MID,  COND_OUT_BUSY,     ST_EMIT_MID};
      ST_UPDATE:    rom = '{OP_UPDATE,    COND_NEVER,        ST_WAIT};
      ST_END_CHK:   rom = '{OP_NOP,       COND_NOT_END,      ST_WAIT};
      ST_LAST_CHK:  rom = '{OP_NOP,       COND_SHORT,        ST_CLEAR};
      ST_EMIT_LAST: rom = '{OP_EMIT_LAST, COND_OUT_BUSY,     ST_EMIT_LAST};
      ST_CLEAR:     rom = '{OP_CLEAR,     COND_ALWAYS,       ST_WAIT};
      default:      rom = '{OP_NOP,       COND_ALWAYS,       ST_WAIT};
    endcase
  endfunction

  step_t     pc_r;
  step_t     pc_nxt;
  ctl_word_t cw;
  logic      take;

  assign cw = rom(pc_r);
  assign op = cw.op;

  // branch resolve
  always_comb begin
    unique case (cw.cond)
      COND_NEVER:        take = 1'b0;
      COND_ALWAYS:       take = 1'b1;
      COND_NO_REQ:       take = flags.no_req;
      COND_FIRST_OR_DUP: take = flags.first_or_dup;
      COND_AXIS:         take = flags.axis;
      COND_LOOP:         take = flags.loop;
      COND_DROP:         take = flags.drop;
      COND_OUT_BUSY:     take = flags.out_busy;
      COND_NOT_END:      take = flags.not_end;
      COND_SHORT:        take = flags.short_stroke;
      default:           take = 1'b0;
    endcase
    pc_nxt = take ? cw.target : pc_r + STEP_W'(1);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* sv/polyline_angle_simplifier_core.sv */
// Angle-threshold polyline simplifier. Points are taken one at a time over a
// valid/ready channel; kept points leave through a registered valid/ready
// output. A small microcode program steps a shared datapath, and the cost of
// an item is set by the shift-add arctangent unit, which runs one iteration
// per cycle. A point that needs a direction is accepted, checked, set up,
// rotated and normalized, then emits its pending point if that is kept and
// closes the stroke if it ends one; an axis-aligned segment skips the
// rotation and a first or duplicate point skips the direction, and the emit
// steps wait for the output to be taken.
// A new point is taken only once the previous one is fully handled.
// The three settings registers should be written only while the block is idle.
module polyline_angle_simplifier_core
  import pas_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  // input points
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic                         in_stroke_end,
  input  logic                         in_close_request,
  // kept points
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic                         out_last_point,
  output logic                         out_path_closed,
  // settings port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [REG_ADDR_W-1:0]        paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  cfg_t   cfg;
  op_t    op;
  flags_t flags;

  // latched request
  logic signed [COORD_BITS-1:0] in_x_r;
  logic signed [COORD_BITS-1:0] in_y_r;
  logic                         in_end_r;
  logic                         in_close_r;

  // stroke state
  logic signed [COORD_BITS-1:0] pend_x_r;
  logic signed [COORD_BITS-1:0] pend_y_r;
  logic [DIR_W-1:0]             prev_dir_r;
  logic [1:0]                   seen_r;

  // working registers
  logic signed [DELTA_W-1:0] dx_r;
  logic signed [DELTA_W-1:0] dy_r;
  logic signed [CW-1:0]      cx_r;
  logic signed [CW-1:0]      cy_r;
  logic signed [ZW-1:0]      cz_r;
  logic [ITER_W-1:0]         iter_r;
  logic [DIR_W-1:0]          dir_r;

  // output register
  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] out_x_r;
  logic signed [COORD_BITS-1:0] out_y_r;
  logic                         out_last_r;
  logic                         out_closed_r;

  logic signed [CW-1:0] cx_step;
  logic signed [CW-1:0] cy_step;
  logic signed [ZW-1:0] cz_step;

  logic signed [CW-1:0] dx_scaled;
  logic signed [CW-1:0] dy_scaled;
  logic                 axis_seg;
  logic [DIR_W-1:0]     axis_dir;
  logic signed [ZW-1:0] z_wrap;
  logic signed [ZW-1:0] z_round;
  logic [DIR_W-1:0]     dir_round;
  logic [DIR_W-1:0]     norm_dir;
  logic                 filter_on;
  logic [ANG_W-1:0]     thr;
  logic [DIR_W-1:0]     diff;
  logic                 out_free;
  logic                 out_load;
  logic                 same_point;

  pas_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pas_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op)
  );

  pas_cordic u_cordic (
    .x      (cx_r),
    .y      (cy_r),
    .z      (cz_r),
    .iter   (iter_r),
    .x_step (cx_step),
    .y_step (cy_step),
    .z_step (cz_step)
  );

  assign in_ready = (op == OP_ACCEPT);
  assign out_free = !out_valid_r || out_ready;
  assign out_load = ((op == OP_EMIT_MID) || (op == OP_EMIT_LAST)) && out_free;

  // deltas scaled by 2^16 for the rotation unit
  assign dx_scaled = CW'(dx_r) <<< FRAC_W;
  assign dy_scaled = CW'(dy_r) <<< FRAC_W;

  // exact directions of axis-aligned segments
  assign axis_seg = (dx_r == '0) || (dy_r == '0);
  always_comb begin
    if (dy_r == '0) begin
      axis_dir = dx_r[DELTA_W-1] ? DIR_WEST : DIR_EAST;
    end else begin
      axis_dir = dy_r[DELTA_W-1] ? DIR_SOUTH : DIR_NORTH;
    end
  end

  // wrap the fine angle into one turn and round to 1/256 degree
  always_comb begin
    if (cz_r[ZW-1]) begin
      z_wrap = cz_r + FULL_TURN_FINE;
    end else if (cz_r >= FULL_TURN_FINE) begin
      z_wrap = cz_r - FULL_TURN_FINE;
    end else begin
      z_wrap = cz_r;
    end
    z_round   = z_wrap + ROUND_HALF;
    dir_round = z_round[DIR_W+7:8];
    norm_dir  = (dir_round >= FULL_TURN) ? DIR_EAST : dir_round;
  end

  // keep or drop the pending point
  assign filter_on = (seen_r == SEEN_TWO) &&
                     ((cfg.draw_mode == MODE_STRAIGHT) || cfg.optimize_enable);
  assign thr  = (cfg.draw_mode == MODE_STRAIGHT) ? cfg.combine_angle : HALF_DEGREE;
  assign diff = (dir_r >= prev_dir_r) ? dir_r - prev_dir_r : prev_dir_r - dir_r;
  assign same_point = (in_x_r == pend_x_r) && (in_y_r == pend_y_r);

  // branch status
  always_comb begin
    flags.no_req       = !in_valid;
    flags.first_or_dup = (seen_r == SEEN_NONE) || same_point;
    flags.axis         = axis_seg;
    flags.loop         = (iter_r != ITER_W'(NSTEPS - 1));
    flags.drop         = filter_on && (ANG_W'(diff) < thr);
    flags.out_busy     = !out_free;
    flags.not_end      = !in_end_r;
    flags.short_stroke = (seen_r != SEEN_TWO);
  end

  // datapath, one operation per microcode step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= SEEN_NONE;
      out_valid_r <= 1'b0;
    end else begin
      // output handshake
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (op)
        OP_NOP: ;
        OP_ACCEPT: begin
          if (in_valid) begin
            in_x_r     <= in_point_x;
            in_y_r     <= in_point_y;
            in_end_r   <= in_stroke_end;
            in_close_r <= in_close_request;
          end
        end
        OP_CHECK: begin
          dx_r <= DELTA_W'(in_x_r) - DELTA_W'(pend_x_r);
          dy_r <= DELTA_W'(in_y_r) - DELTA_W'(pend_y_r);
          if (seen_r == SEEN_NONE) begin
            pend_x_r <= in_x_r;
            pend_y_r <= in_y_r;
            seen_r   <= SEEN_ONE;
          end
        end
        OP_SETUP: begin
          if (axis_seg) begin
            dir_r <= axis_dir;
          end else if (dx_r[DELTA_W-1]) begin
            cx_r   <= -dx_scaled;
            cy_r   <= -dy_scaled;
            cz_r   <= HALF_TURN_FINE;
            iter_r <= '0;
          end else begin
            cx_r   <= dx_scaled;
            cy_r   <= dy_scaled;
            cz_r   <= '0;
            iter_r <= '0;
          end
        end
        OP_ITER: begin
          cx_r   <= cx_step;
          cy_r   <= cy_step;
          cz_r   <= cz_step;
          iter_r <= iter_r + ITER_W'(1);
        end
        OP_NORM: begin
          dir_r <= norm_dir;
        end
        OP_EMIT_MID: begin
          if (out_free) begin
            out_x_r      <= pend_x_r;
            out_y_r      <= pend_y_r;
            out_last_r   <= 1'b0;
            out_closed_r <= 1'b0;
          end
        end
        OP_UPDATE: begin
          prev_dir_r <= dir_r;
          pend_x_r   <= in_x_r;
          pend_y_r   <= in_y_r;
          seen_r     <= SEEN_TWO;
        end
        OP_EMIT_LAST: begin
          if (out_free) begin
            out_x_r      <= pend_x_r;
            out_y_r      <= pend_y_r;
            out_last_r   <= 1'b1;
            out_closed_r <= in_close_r;
          end
        end
        OP_CLEAR: begin
          pend_x_r   <= '0;
          pend_y_r   <= '0;
          prev_dir_r <= '0;
          seen_r     <= SEEN_NONE;
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_last_point  = out_last_r;
  assign out_path_closed = out_closed_r;

  // one request at a time: no second request right after one is taken
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken on two cycles in a row");

  // a closed path is only flagged on the final point
  a_closed_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_path_closed || out_last_point))
    else $error("path_closed set on a point that is not last");

  // a computed direction always lies within one turn
  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(op == OP_NORM) |-> (dir_r < FULL_TURN))
    else $error("direction out of range after normalization");

  // the stroke count is saturated after an update
  a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(op == OP_UPDATE) |-> (seen_r == SEEN_TWO))
    else $error("stroke count not saturated after update");

endmodule
